### rtl/core/xbr_pkg.sv
// Package for the bounded xorshift generator: constants, state type and step function.
`default_nettype none
package xbr_pkg;

  localparam int WORD_W = 64;
  localparam int CNT_W  = $clog2(WORD_W);

  // xorshift shift triple
  localparam int SHIFT_A = 13;
  localparam int SHIFT_B = 7;
  localparam int SHIFT_C = 17;

  // request codes
  localparam logic CMD_RAW   = 1'b0;
  localparam logic CMD_RANGE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_THRESH,
    ST_DRAW,
    ST_MOD,
    ST_FINISH
  } st_t;

  // one generator step
  function automatic logic [WORD_W-1:0] xs_step(input logic [WORD_W-1:0] s);
    logic [WORD_W-1:0] x;
    x = s;
    x = x ^ (x << SHIFT_A);
    x = x ^ (x >> SHIFT_B);
    x = x ^ (x << SHIFT_C);
    return x;
  endfunction

endpackage
`default_nettype wire

### rtl/core/xorshift64_bounded_random.sv
// Top level: xorshift64 generator with rejection-based range reduction.
//
// Requests arrive on in_valid/in_stall with cmd, low_bound and high_bound;
// results leave on out_valid/out_stall with value. A request is taken when
// valid is high and stall low. One request is worked on at a time; in_stall
// is high from acceptance until the result sits in the output register.
// Raw draw (cmd 0): the generator steps at acceptance and value is loaded in ST_FINISH.
// Range draw (cmd 1): bounds are swapped if reversed; an empty span answers
// low_bound with the same timing as a raw draw. Otherwise a radix-2 restoring
// divider, one quotient bit per cycle, works out the rejection threshold in
// ST_THRESH, then one draw per cycle in ST_DRAW until a draw is not below it,
// then the draw modulo span in ST_MOD; value is loaded in ST_FINISH and the
// state returns to ST_IDLE for the next request.
// The output register holds a finished result while out_stall is high; the
// next request is taken only once that result has moved to the output.
// Writing seed (seed_we) loads the state, a zero seed loading one; the user
// must write it only while idle; the block does not enforce it. Synchronous
// reset rst clears the control state and sets the generator state to one.
`default_nettype none
module xorshift64_bounded_random
  import xbr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              seed_we,
  input  wire logic [WORD_W-1:0] seed,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              cmd,
  input  wire logic [WORD_W-1:0] low_bound,
  input  wire logic [WORD_W-1:0] high_bound,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [WORD_W-1:0]      value
);

  st_t               state, state_next;
  logic [WORD_W-1:0] gen;
  logic [WORD_W-1:0] gen_step;
  logic [WORD_W-1:0] lo, span, thresh, res;
  logic [WORD_W-1:0] dq, rem;
  logic [CNT_W-1:0]  cnt;

  // request decode
  logic              accept;
  logic              swap;
  logic [WORD_W-1:0] lo_in, span_in;
  logic              out_free;
  logic              draw_ok;

  assign gen_step = xs_step(gen);
  assign swap     = high_bound < low_bound;
  assign lo_in    = swap ? high_bound : low_bound;
  assign span_in  = swap ? (low_bound - high_bound) : (high_bound - low_bound);
  assign out_free = !out_valid || !out_stall;
  assign draw_ok  = gen_step >= thresh;

  // divider step: shift one dividend bit into the remainder
  logic [WORD_W:0]   rem_sh, rem_diff;
  logic [WORD_W-1:0] rem_next;
  logic              cnt_last;

  assign rem_sh   = {rem, dq[WORD_W-1]};
  assign rem_diff = rem_sh - {1'b0, span};
  assign rem_next = rem_diff[WORD_W] ? rem_sh[WORD_W-1:0] : rem_diff[WORD_W-1:0];
  assign cnt_last = cnt == {CNT_W{1'b1}};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (cmd == CMD_RANGE && span_in != '0) state_next = ST_THRESH;
          else                                   state_next = ST_FINISH;
        end
      end
      ST_THRESH: if (cnt_last) state_next = ST_DRAW;
      ST_DRAW:   if (draw_ok) state_next = ST_MOD;
      ST_MOD:    if (cnt_last) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall = 1'b1;
    accept   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      gen       <= {{(WORD_W-1){1'b0}}, 1'b1};
    end else begin
      state <= state_next;
      if (state == ST_FINISH && out_free) out_valid <= 1'b1;
      else if (!out_stall)                out_valid <= 1'b0;
      if (seed_we) begin
        gen <= (seed != '0) ? seed : {{(WORD_W-1){1'b0}}, 1'b1};
      end else if ((accept && cmd == CMD_RAW) || state == ST_DRAW) begin
        gen <= gen_step;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        lo   <= lo_in;
        span <= span_in;
        dq   <= '0 - span_in;
        rem  <= '0;
        cnt  <= '0;
        res  <= (cmd == CMD_RAW) ? gen_step : lo_in;
      end
      ST_THRESH: begin
        dq  <= {dq[WORD_W-2:0], 1'b0};
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt_last) thresh <= rem_next;
      end
      ST_DRAW: begin
        dq  <= gen_step;
        rem <= '0;
        cnt <= '0;
      end
      ST_MOD: begin
        dq  <= {dq[WORD_W-2:0], 1'b0};
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt_last) res <= rem_next + lo;
      end
      ST_FINISH: if (out_free) value <= res;
      default: ;
    endcase
  end

  // checks
  a_gen_nonzero: assert property (@(posedge clk) disable iff (rst) gen != '0)
    else $error("generator state reached zero");
  a_rem_below_span: assert property (@(posedge clk) disable iff (rst)
    (state == ST_THRESH || state == ST_MOD) && cnt != '0 |-> rem < span)
    else $error("divider remainder not below span");
  a_draw_kept: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAW && state_next == ST_MOD |=> dq >= thresh)
    else $error("rejected draw passed to reduction");
  a_finish_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && out_valid && out_stall |=> state == ST_FINISH)
    else $error("result dropped while output stalled");

endmodule
`default_nettype wire
